>>> rtl/mcur_pkg.sv
// Shared types and constants for the multi-channel ultrasonic ranger.
// Used by the core, the distance converter and the top level; no dependencies.
package mcur_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_TRIGGER_INTERVAL = 2'd0,
        REG_ECHO_TIMEOUT     = 2'd1,
        REG_MAX_DISTANCE     = 2'd2,
        REG_SCALE            = 2'd3
    } reg_index_t;

    // Item kinds carried on tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    localparam int INTERVAL_W = 10;
    localparam int TIMEOUT_W  = 14;
    localparam int MAXDIST_W  = 13;
    localparam int SCALE_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CHAN_W     = 2;
    localparam int CAPTURE_W  = 32;
    localparam int MS_W       = 32;
    localparam int DIST_W     = 14;
    localparam int RES_SENSORS = 3;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd50;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 14'd200;
    localparam logic [MAXDIST_W-1:0]  MAXDIST_RESET  = 13'd6400;
    localparam logic [SCALE_W-1:0]    SCALE_RESET    = 16'd17826;

    // Distance that marks a sensor without a valid reading
    localparam logic signed [DIST_W-1:0] DIST_INVALID = -14'sd16;

    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] trigger_interval_ms;
        logic [TIMEOUT_W-1:0]  echo_timeout_ms;
        logic [MAXDIST_W-1:0]  max_distance_q4;
        logic [SCALE_W-1:0]    scale_q16;
    } cfg_t;

    typedef struct packed {
        logic                 op;
        logic [CHAN_W-1:0]    channel;
        logic [CAPTURE_W-1:0] capture_value;
    } item_t;

    typedef struct packed {
        logic [RES_SENSORS-1:0]             fire_mask;
        logic [RES_SENSORS-1:0]             done_mask;
        logic [RES_SENSORS-1:0][DIST_W-1:0] sensor_dist;
    } result_t;

endpackage

>>> rtl/mcur_dist_conv.sv
// Pulse width to distance conversion: scale multiply, drop 16 fraction bits, clamp.
// Depends on mcur_pkg.
module mcur_dist_conv #(
    parameter int TIMER_BITS = 32
) (
    input  logic [TIMER_BITS-1:0]          pulse,
    input  logic [mcur_pkg::SCALE_W-1:0]   scale_q16,
    input  logic [mcur_pkg::MAXDIST_W-1:0] max_distance_q4,
    output mcur_pkg::dist_t                distance
);

    localparam int PROD_W = TIMER_BITS + mcur_pkg::SCALE_W;

    logic [PROD_W-1:0]     prod;
    logic [TIMER_BITS-1:0] quot;

    // Scale the pulse and keep the integer sixteenths
    assign prod = PROD_W'(pulse) * PROD_W'(scale_q16);
    assign quot = prod[PROD_W-1:mcur_pkg::SCALE_W];

    // Clamp to the configured maximum
    always_comb begin
        if (quot > TIMER_BITS'(max_distance_q4)) begin
            distance = mcur_pkg::dist_t'({1'b0, max_distance_q4});
        end else begin
            distance = mcur_pkg::dist_t'({1'b0, quot[mcur_pkg::MAXDIST_W-1:0]});
        end
    end

endmodule

>>> rtl/mcur_core.sv
// Ranger state and single-pass item processing: tick scheduler, timeouts, echo capture.
// Depends on mcur_pkg and mcur_dist_conv.
module mcur_core #(
    parameter int NUM_SENSORS = 3,
    parameter int TIMER_BITS  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  mcur_pkg::item_t     item,
    input  mcur_pkg::cfg_t      cfg,
    output mcur_pkg::result_t   result
);

    localparam int SEL_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SHOWN = (NUM_SENSORS < mcur_pkg::RES_SENSORS) ? NUM_SENSORS
                                                                  : mcur_pkg::RES_SENSORS;
    localparam int MS_W  = mcur_pkg::MS_W;

    logic [MS_W-1:0]        now_reg, now_next;
    logic [SEL_W-1:0]       sensor_reg, sensor_next;
    logic [MS_W-1:0]        sched_reg, sched_next;
    logic [MS_W-1:0]        fire_time_reg [NUM_SENSORS];
    logic [MS_W-1:0]        fire_time_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] complete_reg, complete_next;
    logic [NUM_SENSORS-1:0] phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  rise_reg [NUM_SENSORS];
    logic [TIMER_BITS-1:0]  rise_next [NUM_SENSORS];
    mcur_pkg::dist_t        dist_reg [NUM_SENSORS];
    mcur_pkg::dist_t        dist_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] fire;

    logic [MS_W-1:0]        now_inc;
    logic                   cur_complete;
    logic [TIMER_BITS-1:0]  cap_val;
    logic [TIMER_BITS-1:0]  sel_rise;
    logic [TIMER_BITS-1:0]  pulse;
    mcur_pkg::dist_t        new_dist;

    assign now_inc = now_reg + 1'b1;
    assign cap_val = item.capture_value[TIMER_BITS-1:0];
    assign pulse   = cap_val - sel_rise;

    // Pick per-sensor values addressed by the scheduler and by the capture channel
    always_comb begin
        cur_complete = 1'b0;
        sel_rise     = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (sensor_reg == SEL_W'(i)) begin
                cur_complete = complete_reg[i];
            end
            if (int'(item.channel) == i) begin
                sel_rise = rise_reg[i];
            end
        end
    end

    mcur_dist_conv #(
        .TIMER_BITS(TIMER_BITS)
    ) u_dist_conv (
        .pulse           (pulse),
        .scale_q16       (cfg.scale_q16),
        .max_distance_q4 (cfg.max_distance_q4),
        .distance        (new_dist)
    );

    // Next state for one word
    always_comb begin
        now_next      = now_reg;
        sensor_next   = sensor_reg;
        sched_next    = sched_reg;
        fire_time_next = fire_time_reg;
        complete_next = complete_reg;
        phase_next    = phase_reg;
        rise_next     = rise_reg;
        dist_next     = dist_reg;
        fire          = '0;
        if (item.op == mcur_pkg::OP_TICK) begin
            now_next = now_inc;
            // Round-robin trigger offer
            if (cur_complete &&
                ((now_inc - sched_reg) > MS_W'(cfg.trigger_interval_ms))) begin
                sched_next = now_inc;
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    if (sensor_reg == SEL_W'(i)) begin
                        complete_next[i]  = 1'b0;
                        fire_time_next[i] = now_inc;
                        fire[i]           = 1'b1;
                    end
                end
                if (sensor_reg == SEL_W'(NUM_SENSORS - 1)) begin
                    sensor_next = '0;
                end else begin
                    sensor_next = sensor_reg + 1'b1;
                end
            end
            // Echo timeouts, after the trigger decision
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (!complete_next[i] &&
                    ((now_inc - fire_time_next[i]) > MS_W'(cfg.echo_timeout_ms))) begin
                    complete_next[i] = 1'b1;
                end
            end
        end else begin
            // Echo edge: rising stores the time, falling measures
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (int'(item.channel) == i) begin
                    if (!phase_reg[i]) begin
                        rise_next[i]  = cap_val;
                        phase_next[i] = 1'b1;
                    end else begin
                        dist_next[i]     = new_dist;
                        phase_next[i]    = 1'b0;
                        complete_next[i] = 1'b1;
                    end
                end
            end
        end
    end

    // Result word from the updated state
    always_comb begin
        result.fire_mask = '0;
        result.done_mask = '0;
        for (int k = 0; k < mcur_pkg::RES_SENSORS; k++) begin
            result.sensor_dist[k] = mcur_pkg::DIST_INVALID;
        end
        for (int i = 0; i < SHOWN; i++) begin
            result.fire_mask[i]   = fire[i];
            result.done_mask[i]   = complete_next[i];
            result.sensor_dist[i] = dist_next[i];
        end
    end

    // Hold state, advance on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            sensor_reg   <= '0;
            sched_reg    <= '0;
            complete_reg <= '1;
            phase_reg    <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                fire_time_reg[i] <= '0;
                dist_reg[i]      <= mcur_pkg::DIST_INVALID;
            end
        end else if (advance) begin
            now_reg       <= now_next;
            sensor_reg    <= sensor_next;
            sched_reg     <= sched_next;
            complete_reg  <= complete_next;
            phase_reg     <= phase_next;
            fire_time_reg <= fire_time_next;
            dist_reg      <= dist_next;
        end
    end

    // Rise times are payload: no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            rise_reg <= rise_next;
        end
    end

endmodule

>>> rtl/multi_channel_ultrasonic_ranger_unit.sv
// Multi-channel ultrasonic ranger: input register, single-pass core, result register.
// Depends on mcur_pkg, mcur_core and mcur_dist_conv.
// A word accepted into the input register passes through the core and is loaded into the
// result register when that register can take it; m_tvalid then offers it.
// Throughput: one word per cycle while the result side is not stalled; the core step is
// combinational between registers; a stalled result register holds the input side.
// Reset (aresetn low, synchronous): both registers empty, configuration at defaults,
// all sensors complete, distances invalid.
module multi_channel_ultrasonic_ranger_unit #(
    parameter int NUM_SENSORS = 3,
    parameter int TIMER_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] channel, [33:2] capture_value, zero fill
    input  logic        s_tuser,   // op
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] fire_mask, [5:3] done_mask, [19:6] front_distance,
    // [33:20] left_distance, [47:34] right_distance
    output logic [47:0] m_tdata
);

    mcur_pkg::cfg_t    cfg_reg;
    mcur_pkg::item_t   item_reg;
    logic              in_valid_reg;
    mcur_pkg::result_t res_reg;
    mcur_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              advance;

    // Core step when a word is held and the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_interval_ms <= mcur_pkg::INTERVAL_RESET;
            cfg_reg.echo_timeout_ms     <= mcur_pkg::TIMEOUT_RESET;
            cfg_reg.max_distance_q4     <= mcur_pkg::MAXDIST_RESET;
            cfg_reg.scale_q16           <= mcur_pkg::SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (mcur_pkg::reg_index_t'(cfg_index))
                mcur_pkg::REG_TRIGGER_INTERVAL:
                    cfg_reg.trigger_interval_ms <= cfg_wdata[mcur_pkg::INTERVAL_W-1:0];
                mcur_pkg::REG_ECHO_TIMEOUT:
                    cfg_reg.echo_timeout_ms <= cfg_wdata[mcur_pkg::TIMEOUT_W-1:0];
                mcur_pkg::REG_MAX_DISTANCE:
                    cfg_reg.max_distance_q4 <= cfg_wdata[mcur_pkg::MAXDIST_W-1:0];
                mcur_pkg::REG_SCALE:
                    cfg_reg.scale_q16 <= cfg_wdata[mcur_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op            <= s_tuser;
            item_reg.channel       <= s_tdata[1:0];
            item_reg.capture_value <= s_tdata[33:2];
        end
    end

    mcur_core #(
        .NUM_SENSORS(NUM_SENSORS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    // Result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.sensor_dist[2], res_reg.sensor_dist[1], res_reg.sensor_dist[0],
                       res_reg.done_mask, res_reg.fire_mask};

    // At most one sensor fires per tick
    a_one_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(res_reg.fire_mask))
        else $error("more than one sensor fired in one tick");

    // A sensor fired in this tick cannot be complete in the same word
    a_fire_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res_reg.fire_mask & res_reg.done_mask) == '0))
        else $error("fired sensor reported complete");

    // Negative distances are only the invalid marker
    a_dist_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ((!res_reg.sensor_dist[0][13] || res_reg.sensor_dist[0] == mcur_pkg::DIST_INVALID) &&
             (!res_reg.sensor_dist[1][13] || res_reg.sensor_dist[1] == mcur_pkg::DIST_INVALID) &&
             (!res_reg.sensor_dist[2][13] || res_reg.sensor_dist[2] == mcur_pkg::DIST_INVALID)))
        else $error("negative distance other than invalid marker");

    // A stalled result word holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for multi_channel_ultrasonic_ranger_unit: directed scheduler and
// echo cases, then register sweeps with random ticks and captures under random stalls.
// Depends on mcur_pkg and the RTL of the ranger unit.
module testbench;

    typedef struct packed {
        logic [2:0]      fire;
        logic [2:0]      done;
        mcur_pkg::dist_t front;
        mcur_pkg::dist_t left;
        mcur_pkg::dist_t right;
    } ranging_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    mcur_pkg::reg_index_t cfg_index = mcur_pkg::REG_TRIGGER_INTERVAL;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // [1:0] channel, [33:2] capture_value, zero fill
    logic                 s_tuser   = 1'b0; // op
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] fire_mask, [5:3] done_mask, [19:6] front_distance,
    // [33:20] left_distance, [47:34] right_distance
    logic [47:0]          m_tdata;

    // Predicted ranger state and registers
    logic [mcur_pkg::INTERVAL_W-1:0] trig_interval;
    logic [mcur_pkg::TIMEOUT_W-1:0]  echo_timeout;
    logic [mcur_pkg::MAXDIST_W-1:0]  dist_limit;
    logic [mcur_pkg::SCALE_W-1:0]    q16_scale;
    logic [31:0]           now_ms;
    logic [31:0]           last_sched_ms;
    logic [1:0]            next_sensor;
    logic [31:0]           fire_ms [3];
    logic [2:0]            sensor_done;
    logic [2:0]            await_fall;
    logic [31:0]           rise_stamp [3];
    mcur_pkg::dist_t       dist_q4 [3];

    ranging_result_t expected_results [$];
    int              mismatches = 0;
    bit              no_gaps = 1'b0;
    logic [31:0]     last_edge [4];

    multi_channel_ultrasonic_ranger_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void ranger_reset_state();
        trig_interval = mcur_pkg::INTERVAL_RESET;
        echo_timeout  = mcur_pkg::TIMEOUT_RESET;
        dist_limit    = mcur_pkg::MAXDIST_RESET;
        q16_scale     = mcur_pkg::SCALE_RESET;
        now_ms        = '0;
        last_sched_ms = '0;
        next_sensor   = '0;
        sensor_done   = 3'b111;
        await_fall    = 3'b000;
        for (int i = 0; i < 3; i++) begin
            fire_ms[i]    = '0;
            rise_stamp[i] = '0;
            dist_q4[i]    = mcur_pkg::DIST_INVALID;
        end
    endfunction

    // Apply one word to the predicted state and return the result it causes
    function automatic ranging_result_t ranger_predict(logic op, logic [1:0] ch,
                                                       logic [31:0] val);
        ranging_result_t r;
        logic [1:0]  cur;
        logic [31:0] pulse;
        logic [63:0] q;
        r.fire = '0;
        if (op == mcur_pkg::OP_TICK) begin
            now_ms = now_ms + 32'd1;
            cur = next_sensor;
            // Trigger the scheduled sensor if it is idle and the interval has passed
            if (sensor_done[cur] && (now_ms - last_sched_ms) > 32'(trig_interval)) begin
                sensor_done[cur] = 1'b0;
                fire_ms[cur]     = now_ms;
                last_sched_ms    = now_ms;
                r.fire[cur]      = 1'b1;
                cur = (cur == 2'd2) ? 2'd0 : cur + 2'd1;
            end
            next_sensor = cur;
            // Time out sensors still waiting for an echo
            for (int i = 0; i < 3; i++) begin
                if (!sensor_done[i] && (now_ms - fire_ms[i]) > 32'(echo_timeout))
                    sensor_done[i] = 1'b1;
            end
        end else if (ch < 2'd3) begin
            if (!await_fall[ch]) begin
                rise_stamp[ch] = val;
                await_fall[ch] = 1'b1;
            end else begin
                pulse = val - rise_stamp[ch];
                q = (64'(pulse) * 64'(q16_scale)) >> 16;
                if (q > 64'(dist_limit))
                    q = 64'(dist_limit);
                dist_q4[ch]     = q[mcur_pkg::DIST_W-1:0];
                await_fall[ch]  = 1'b0;
                sensor_done[ch] = 1'b1;
            end
        end
        r.done  = sensor_done;
        r.front = dist_q4[0];
        r.left  = dist_q4[1];
        r.right = dist_q4[2];
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one word; called and returning at a falling edge
    task automatic send_word(logic op, logic [1:0] ch, logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, val, ch};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(ranger_predict(op, ch, val));
        @(negedge aclk);
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(mcur_pkg::reg_index_t idx, logic [15:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mcur_pkg::REG_TRIGGER_INTERVAL:
                trig_interval = value[mcur_pkg::INTERVAL_W-1:0];
            mcur_pkg::REG_ECHO_TIMEOUT:
                echo_timeout  = value[mcur_pkg::TIMEOUT_W-1:0];
            mcur_pkg::REG_MAX_DISTANCE:
                dist_limit    = value[mcur_pkg::MAXDIST_W-1:0];
            mcur_pkg::REG_SCALE:
                q16_scale     = value[mcur_pkg::SCALE_W-1:0];
        endcase
    endtask

    // Random mix: ticks, echo edges with realistic pulse widths, stray channel
    task automatic random_items(int count);
        int          r;
        logic [1:0]  ch;
        logic [31:0] step;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                no_gaps = !no_gaps;
            if ($urandom_range(0, 149) == 0)
                drain_results();
            if (r < 55) begin
                send_word(mcur_pkg::OP_TICK, 2'($urandom_range(0, 3)), $urandom);
            end else begin
                ch = (r < 95) ? 2'($urandom_range(0, 2)) : 2'd3;
                r = $urandom_range(0, 99);
                if (r < 75)
                    step = $urandom_range(0, 40000);
                else if (r < 88)
                    step = $urandom_range(0, 255);
                else
                    step = $urandom;
                last_edge[ch] = (r >= 96) ? $urandom : last_edge[ch] + step;
                send_word(mcur_pkg::OP_CAPTURE, ch, last_edge[ch]);
            end
        end
    endtask

    // Default registers: an idle tick, wrapped, clamped and zero-width pulses, stray channel
    task automatic test_reset_defaults();
        send_word(mcur_pkg::OP_TICK, 2'd0, 32'd0);
        send_word(mcur_pkg::OP_CAPTURE, 2'd3, 32'hFFFF_FFFF);
        send_word(mcur_pkg::OP_CAPTURE, 2'd0, 32'hFFFF_FFF0);
        send_word(mcur_pkg::OP_CAPTURE, 2'd0, 32'h0000_0010);
        send_word(mcur_pkg::OP_CAPTURE, 2'd1, 32'h0000_0000);
        send_word(mcur_pkg::OP_CAPTURE, 2'd1, 32'hFFFF_FFFF);
        send_word(mcur_pkg::OP_CAPTURE, 2'd2, 32'h1234_5678);
        send_word(mcur_pkg::OP_CAPTURE, 2'd2, 32'h1234_5678);
    endtask

    // Short interval and timeout: firing, busy sensor, timeout, echo on a fired sensor
    task automatic test_scheduler_directed();
        write_register(mcur_pkg::REG_TRIGGER_INTERVAL, 16'd1);
        write_register(mcur_pkg::REG_ECHO_TIMEOUT, 16'd1);
        repeat (3) send_word(mcur_pkg::OP_TICK, 2'd3, 32'hAAAA_5555);
        send_word(mcur_pkg::OP_CAPTURE, 2'd1, 32'd100);
        send_word(mcur_pkg::OP_CAPTURE, 2'd1, 32'd2000);
        repeat (4) send_word(mcur_pkg::OP_TICK, 2'd0, 32'h5555_AAAA);
        // Clamp at the widest limit, then a zero scale
        write_register(mcur_pkg::REG_MAX_DISTANCE, 16'hFFFF);
        write_register(mcur_pkg::REG_SCALE, 16'hFFFF);
        send_word(mcur_pkg::OP_CAPTURE, 2'd0, 32'd0);
        send_word(mcur_pkg::OP_CAPTURE, 2'd0, 32'hFFFF_FFFF);
        write_register(mcur_pkg::REG_SCALE, 16'd0);
        send_word(mcur_pkg::OP_CAPTURE, 2'd2, 32'd7);
        send_word(mcur_pkg::OP_CAPTURE, 2'd2, 32'd70000);
    endtask

    // Registers at their widest, masked to zero, and at large in-range values
    task automatic test_extreme_settings();
        write_register(mcur_pkg::REG_TRIGGER_INTERVAL, 16'hFFFF);
        write_register(mcur_pkg::REG_ECHO_TIMEOUT, 16'hFFFF);
        write_register(mcur_pkg::REG_MAX_DISTANCE, 16'hFFFF);
        write_register(mcur_pkg::REG_SCALE, 16'hFFFF);
        random_items(60);
        write_register(mcur_pkg::REG_TRIGGER_INTERVAL, 16'h0400);
        write_register(mcur_pkg::REG_ECHO_TIMEOUT, 16'h4000);
        write_register(mcur_pkg::REG_MAX_DISTANCE, 16'h0000);
        write_register(mcur_pkg::REG_SCALE, 16'h0000);
        random_items(80);
        write_register(mcur_pkg::REG_TRIGGER_INTERVAL, 16'd1000);
        write_register(mcur_pkg::REG_ECHO_TIMEOUT, 16'd10000);
        write_register(mcur_pkg::REG_MAX_DISTANCE, 16'd8191);
        write_register(mcur_pkg::REG_SCALE, 16'd65535);
        random_items(60);
    endtask

    // One setting with small timings so that sensors fire and time out often
    task automatic test_random_ranging(int count, int max_interval, int max_timeout);
        write_register(mcur_pkg::REG_TRIGGER_INTERVAL, 16'($urandom_range(0, max_interval)));
        write_register(mcur_pkg::REG_ECHO_TIMEOUT, 16'($urandom_range(0, max_timeout)));
        write_register(mcur_pkg::REG_MAX_DISTANCE, 16'($urandom_range(0, 8191)));
        write_register(mcur_pkg::REG_SCALE, 16'($urandom_range(1000, 30000)));
        random_items(count);
    endtask

    // Result side: ready runs and stalls, mostly short, a few long
    initial begin
        int len;
        @(negedge aclk);
        forever begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                              : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (len) @(negedge aclk);
            len = $urandom_range(0, 99);
            len = (len < 70) ? $urandom_range(1, 2)
                : (len < 95) ? $urandom_range(3, 6) : $urandom_range(15, 40);
            m_tready <= 1'b0;
            repeat (len) @(negedge aclk);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        ranging_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no expectation: %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("fire_mask", want.fire, m_tdata[2:0]);
                check_field("done_mask", want.done, m_tdata[5:3]);
                check_field("front_distance", want.front,
                            int'(mcur_pkg::dist_t'(m_tdata[19:6])));
                check_field("left_distance", want.left,
                            int'(mcur_pkg::dist_t'(m_tdata[33:20])));
                check_field("right_distance", want.right,
                            int'(mcur_pkg::dist_t'(m_tdata[47:34])));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        ranger_reset_state();
        for (int i = 0; i < 4; i++)
            last_edge[i] = $urandom;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_scheduler_directed();
        test_extreme_settings();
        test_random_ranging(300, 3, 10);
        test_random_ranging(300, 8, 40);
        test_random_ranging(300, 0, 0);
        test_random_ranging(300, 20, 120);
        test_random_ranging(300, 2, 5);
        drain_results();
        repeat (16) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/mcur_pkg.sv
rtl/mcur_dist_conv.sv
rtl/mcur_core.sv
rtl/multi_channel_ultrasonic_ranger_unit.sv
verif/testbench.sv
